// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/b2dt_pkg.sv =====
// ----------------------------------------------------------------------------
// b2dt_pkg
// types, constants and the power-of-two digit table for decimal text
// ----------------------------------------------------------------------------
package b2dt_pkg;

  localparam int DigitCount = 5;
  localparam int BitCount   = 16;
  localparam int BitIdxW    = $clog2(BitCount);
  localparam int PosW       = $clog2(DigitCount);

  localparam logic [5:0] AsciiZero  = 6'h30;
  localparam logic [5:0] AsciiSpace = 6'h20;

  typedef logic [3:0] bcd_t;
  // index 0 is the most significant digit
  typedef bcd_t [0:DigitCount-1] text_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_STRIP,
    S_EMIT
  } state_t;

  // decimal digits of 2**b, packed bcd reads like the decimal number
  function automatic text_t pow2_digits(logic [BitIdxW-1:0] b);
    text_t d;
    case (b)
      4'd0:    d = 20'h00001;
      4'd1:    d = 20'h00002;
      4'd2:    d = 20'h00004;
      4'd3:    d = 20'h00008;
      4'd4:    d = 20'h00016;
      4'd5:    d = 20'h00032;
      4'd6:    d = 20'h00064;
      4'd7:    d = 20'h00128;
      4'd8:    d = 20'h00256;
      4'd9:    d = 20'h00512;
      4'd10:   d = 20'h01024;
      4'd11:   d = 20'h02048;
      4'd12:   d = 20'h04096;
      4'd13:   d = 20'h08192;
      4'd14:   d = 20'h16384;
      4'd15:   d = 20'h32768;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/binary_to_decimal_text_top.sv =====
// sequence: accept in idle, one bit step per value bit, strip steps (one per leading zero plus a check)
// one item at a time: a new value is accepted only after the last character of the previous one is taken
// the bit loop runs over the shared bcd adder, one value bit per cycle
// reset: rst (synchronous) returns the sequencer to idle; no data is cleared
// ----------------------------------------------------------------------------
// binary_to_decimal_text_top
// 16-bit unsigned value to five ascii characters with leading zero removal
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_to_decimal_text_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] base_address,
  input  logic [15:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] write_address,
  output logic [5:0]  character,
  output logic        last_char
);
  import b2dt_pkg::*;

  state_t              state, state_next;
  logic [15:0]         base, base_next;
  logic [15:0]         val, val_next;
  text_t               acc, acc_next;
  logic [BitIdxW-1:0]  bit_idx, bit_idx_next;
  logic [PosW-1:0]     pad, pad_next;
  logic [PosW-1:0]     pos, pos_next;
  text_t               addend;
  text_t               sum;
  logic                in_digits;

  assign addend = pow2_digits(bit_idx);

  b2dt_bcd_add u_add (
    .a   (acc),
    .b   (addend),
    .sum (sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bit_idx <= '0;
      pad     <= '0;
      pos     <= '0;
    end else begin
      state   <= state_next;
      bit_idx <= bit_idx_next;
      pad     <= pad_next;
      pos     <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    base <= base_next;
    val  <= val_next;
    acc  <= acc_next;
  end

  // digits fill the front, spaces the back
  assign in_digits = ({1'b0, pos} + {1'b0, pad}) < (PosW + 1)'(DigitCount);

  always_comb begin
    state_next   = state;
    base_next    = base;
    val_next     = val;
    acc_next     = acc;
    bit_idx_next = bit_idx;
    pad_next     = pad;
    pos_next     = pos;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          base_next    = base_address;
          val_next     = value;
          acc_next     = '0;
          bit_idx_next = '0;
          pad_next     = '0;
          state_next   = S_ADD;
        end
      end
      S_ADD: begin
        if (val[bit_idx]) begin
          acc_next = sum;
        end
        bit_idx_next = bit_idx + 1'b1;
        if (bit_idx == BitIdxW'(BitCount - 1)) begin
          state_next = S_STRIP;
        end
      end
      S_STRIP: begin
        if (pad < PosW'(DigitCount - 1) && acc[0] == 4'd0) begin
          for (int k = 0; k < DigitCount - 1; k++) begin
            acc_next[k] = acc[k + 1];
          end
          acc_next[DigitCount - 1] = 4'd0;
          pad_next = pad + 1'b1;
        end else begin
          pos_next   = '0;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          pos_next = pos + 1'b1;
          if (pos == PosW'(DigitCount - 1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign write_address = base + 16'(pos);
  assign character     = in_digits ? (AsciiZero | {2'b00, acc[pos]}) : AsciiSpace;
  assign last_char     = (pos == PosW'(DigitCount - 1));

  `ASSERT_ALWAYS(a_no_overlap, clk, rst, !(in_ready && out_valid))
  `ASSERT_NEXT(a_start_add, clk, rst, in_valid && in_ready, state == S_ADD && bit_idx == '0)
  `ASSERT_NEXT(a_last_frees, clk, rst, out_valid && out_ready && last_char, in_ready)
  `ASSERT_ALWAYS(a_pad_range, clk, rst, !out_valid || pad <= PosW'(DigitCount - 1))
  `ASSERT_ALWAYS(a_first_digit, clk, rst, !out_valid || acc[0] != 4'd0 || pad == PosW'(DigitCount - 1))

endmodule

// ===== hdl/b2dt_bcd_add.sv =====
// ----------------------------------------------------------------------------
// b2dt_bcd_add
// five-digit bcd adder with digit-to-digit carry, carry out of the top dropped
// ----------------------------------------------------------------------------
module b2dt_bcd_add (
  input  b2dt_pkg::text_t a,
  input  b2dt_pkg::text_t b,
  output b2dt_pkg::text_t sum
);
  import b2dt_pkg::*;

  always_comb begin
    logic       carry;
    logic [4:0] s;
    carry = 1'b0;
    s     = '0;
    sum   = '0;
    for (int d = DigitCount - 1; d >= 0; d--) begin
      s = {1'b0, a[d]} + {1'b0, b[d]} + {4'b0, carry};
      if (s > 5'd9) begin
        s     = s - 5'd10;
        carry = 1'b1;
      end else begin
        carry = 1'b0;
      end
      sum[d] = s[3:0];
    end
  end

endmodule

// ===== tb/sv/binary_to_decimal_text_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_text_top_tb
// drives directed and random values with base addresses into the decimal text
// converter, takes the five character words from the case table or predicts
// them by repeated division and leading zero removal, and checks every word in
// order while both sides idle and stall at random
// ----------------------------------------------------------------------------
module binary_to_decimal_text_top_tb;
  import b2dt_pkg::*;

  localparam int RandomItems = 340;
  localparam int QuietItems  = 40;
  localparam int DrainCycles = 40;
  localparam int CaseCount   = 21;

  localparam logic [39:0] NoText = '0;

  typedef struct packed {
    logic [15:0] addr;
    logic [5:0]  ch;
    logic        last;
  } char_word_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [15:0] val;
    logic [39:0] text;
  } text_case_t;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [15:0] base_address   = '0;
  logic [15:0] value          = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [15:0] write_address;
  logic [5:0]  character;
  logic        last_char;

  char_word_t char_q[$];
  int         mismatches = 0;
  bit         quiet      = 1'b0;
  bit         gaps_on    = 1'b1;

  // text of NoText means the row is checked against the predictor
  text_case_t text_cases [CaseCount] = '{
    '{16'h0000, 16'd0,     "0    "},
    '{16'hFFFF, 16'd65535, "65535"},
    '{16'h1234, 16'd1,     "1    "},
    '{16'h0100, 16'd9,     "9    "},
    '{16'h0200, 16'd10,    "10   "},
    '{16'h0300, 16'd99,    "99   "},
    '{16'h0400, 16'd100,   "100  "},
    '{16'h0500, 16'd999,   "999  "},
    '{16'h0600, 16'd1000,  "1000 "},
    '{16'h0700, 16'd9999,  "9999 "},
    '{16'h0800, 16'd10000, "10000"},
    '{16'h8000, 16'd32768, "32768"},
    '{16'h7FFF, 16'd32767, "32767"},
    '{16'hFFFC, 16'd65534, "65534"},
    '{16'hFFFE, 16'd0,     "0    "},
    '{16'h8000, 16'd12345, "12345"},
    '{16'h0900, 16'd60000, "60000"},
    '{16'hAAAA, 16'h5555,  NoText},
    '{16'h5555, 16'hAAAA,  NoText},
    '{16'hFFFD, 16'd1024,  NoText},
    '{16'h0001, 16'd4095,  NoText}
  };

  binary_to_decimal_text_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .base_address   (base_address),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .write_address  (write_address),
    .character      (character),
    .last_char      (last_char)
  );

  always #5 clk = ~clk;

  // five ascii characters, leading zeros moved to the right as spaces
  function automatic logic [39:0] decimal_text(input logic [15:0] val);
    logic [7:0]  chars [DigitCount];
    logic [39:0] text;
    int          rest;
    rest = val;
    for (int k = DigitCount - 1; k >= 0; k--) begin
      chars[k] = {2'b00, AsciiZero} | 8'(rest % 10);
      rest = rest / 10;
    end
    for (int p = 0; p < DigitCount - 1; p++) begin
      if (chars[0] == {2'b00, AsciiZero}) begin
        for (int k = 0; k < DigitCount - 1; k++) begin
          chars[k] = chars[k + 1];
        end
        chars[DigitCount - 1] = {2'b00, AsciiSpace};
      end
    end
    for (int k = 0; k < DigitCount; k++) begin
      text[39 - 8 * k -: 8] = chars[k];
    end
    return text;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // drive one word, wait for acceptance, then queue its five character writes
  task automatic send_value(input logic [15:0] addr, input logic [15:0] val,
                            input logic [39:0] typed);
    logic [39:0] text;
    logic [7:0]  c;
    char_word_t  w;
    in_valid       <= 1'b1;
    base_address   <= addr;
    value          <= val;
    do @(posedge clk); while (!in_ready);
    text = (typed == NoText) ? decimal_text(val) : typed;
    for (int k = 0; k < DigitCount; k++) begin
      c      = text[39 - 8 * k -: 8];
      w.addr = addr + 16'(k);
      w.ch   = c[5:0];
      w.last = (k == DigitCount - 1);
      char_q.push_back(w);
    end
    if (gaps_on && !quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : check_words
    char_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      if (char_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word addr %h char %h last %b",
                                  write_address, character, last_char));
      end else begin
        exp_w = char_q.pop_front();
        if (write_address !== exp_w.addr)
          report_mismatch($sformatf("write_address %h, expected %h",
                                    write_address, exp_w.addr));
        if (character !== exp_w.ch)
          report_mismatch($sformatf("character %h at %h, expected %h",
                                    character, exp_w.addr, exp_w.ch));
        if (last_char !== exp_w.last)
          report_mismatch($sformatf("last_char %b at %h, expected %b",
                                    last_char, exp_w.addr, exp_w.last));
      end
    end
  end

  // receiver: stall bursts between runs of ready
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [15:0] addr;
    logic [15:0] val;
    int          kind;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < CaseCount; i++) begin
      send_value(text_cases[i].addr, text_cases[i].val, text_cases[i].text);
    end

    // hold off until the converter has drained completely
    in_valid <= 1'b0;
    while (char_q.size() != 0) @(posedge clk);
    @(posedge clk);

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 25 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (i >= RandomItems - QuietItems) quiet = 1'b1;
      kind = $urandom_range(0, 7);
      case (kind)
        0:       val = 16'($urandom_range(0, 9));
        1:       val = 16'($urandom_range(0, 99));
        2:       val = 16'($urandom_range(0, 9999));
        3:       val = 16'($urandom_range(65500, 65535));
        default: val = 16'($urandom_range(0, 65535));
      endcase
      if ($urandom_range(0, 7) == 0) addr = 16'($urandom_range(65531, 65535));
      else addr = 16'($urandom_range(0, 65535));
      send_value(addr, val, NoText);
    end

    in_valid <= 1'b0;
    while (char_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/b2dt_pkg.sv
hdl/b2dt_bcd_add.sv
hdl/binary_to_decimal_text_top.sv
tb/sv/binary_to_decimal_text_top_tb.sv
